### design/pcd_pkg.sv
// Shared types and constants for the clamped PID / PWM duty block.
// Holds the sequencer control word, operand select codes and field widths.
// No dependencies.
`timescale 1ns / 1ps

package pcd_pkg;

	// Port and field widths.
	localparam int unsigned SAMPLE_W   = 10;
	localparam int unsigned PCT_W      = 7;
	localparam int unsigned GAIN_W     = 8;
	localparam int unsigned DRIVE_W    = 8;
	localparam int unsigned DUTY_W     = 10;
	localparam int unsigned ADDR_W     = 4;
	localparam int unsigned DATA_W     = 32;

	// Internal datapath widths.
	localparam int unsigned TGT_W      = 9;
	localparam int unsigned ERR_W      = 11;
	localparam int unsigned SUM_W      = 7;
	localparam int unsigned DERIV_W    = 12;
	localparam int unsigned MUL_A_W    = 10;
	localparam int unsigned MUL_B_W    = 12;
	localparam int unsigned PROD_W     = MUL_A_W + MUL_B_W;
	localparam int unsigned PC_W       = 4;

	// Default parameter values.
	localparam int unsigned SAMPLE_BITS_DEF = 10;
	localparam int unsigned PWM_PERIOD_DEF  = 1000;

	// Behavioral constants.
	localparam int SUM_LIMIT    = 50;
	localparam int DRIVE_MAX    = 255;
	localparam int TARGET_SCALE = 255;

	// Target = pct*255/100 is done as a multiply by 255*ceil(2^19/100), then a shift.
	localparam int unsigned TGT_RECIP  = 5243;
	localparam int unsigned TGT_SHIFT  = 19;
	localparam int unsigned TGT_PROD_W = TGT_SHIFT + TGT_W;
	localparam int unsigned TGT_MULT   = TARGET_SCALE * TGT_RECIP;

	// Register indexes of the configuration port.
	localparam logic [1:0] REG_TARGET = 2'd0;
	localparam logic [1:0] REG_GAIN_P = 2'd1;
	localparam logic [1:0] REG_GAIN_I = 2'd2;
	localparam logic [1:0] REG_GAIN_D = 2'd3;

	typedef enum logic [2:0] {
		MA_GP,
		MA_GI,
		MA_GD,
		MA_PA,
		MA_PB
	} mul_a_sel_t;

	typedef enum logic [1:0] {
		MB_ERR,
		MB_SUM,
		MB_DERIV,
		MB_DRIVE
	} mul_b_sel_t;

	typedef enum logic [1:0] {
		ACC_HOLD,
		ACC_LOAD,
		ACC_ADD
	} acc_op_t;

	typedef enum logic {
		JMP_NONE,
		JMP_OUT_BUSY
	} jmp_t;

	typedef struct packed {
		mul_a_sel_t       mul_a;
		mul_b_sel_t       mul_b;
		logic             mul_en;
		acc_op_t          acc_op;
		logic             ld_err;
		logic             ld_state;
		logic             ld_drive;
		logic             ld_out;
		logic             last;
		jmp_t             jmp;
		logic [PC_W-1:0]  jmp_to;
	} ctrl_t;

	localparam ctrl_t CTRL_NOP = '{
		mul_a:    MA_GP,
		mul_b:    MB_ERR,
		mul_en:   1'b0,
		acc_op:   ACC_HOLD,
		ld_err:   1'b0,
		ld_state: 1'b0,
		ld_drive: 1'b0,
		ld_out:   1'b0,
		last:     1'b0,
		jmp:      JMP_NONE,
		jmp_to:   '0
	};

endpackage

### design/pcd_seq.sv
// Microcode sequencer: step counter, program table and the wait-for-output jump.
// Emits one control word per cycle to the datapath, a NOP while idle or waiting.
// Depends on pcd_pkg.
`timescale 1ns / 1ps

module pcd_seq
	import pcd_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  start,
	input  logic  out_busy,
	output ctrl_t ctrl,
	output logic  busy
);

	localparam logic [PC_W-1:0] STEP_ERR     = 4'd0;
	localparam logic [PC_W-1:0] STEP_STATE   = 4'd1;
	localparam logic [PC_W-1:0] STEP_ACC_I   = 4'd2;
	localparam logic [PC_W-1:0] STEP_ACC_D   = 4'd3;
	localparam logic [PC_W-1:0] STEP_ACC_END = 4'd4;
	localparam logic [PC_W-1:0] STEP_CLAMP   = 4'd5;
	localparam logic [PC_W-1:0] STEP_DUTY_A  = 4'd6;
	localparam logic [PC_W-1:0] STEP_DUTY_B  = 4'd7;
	localparam logic [PC_W-1:0] STEP_OUT     = 4'd8;

	function automatic ctrl_t pcd_rom(input logic [PC_W-1:0] pc);
		ctrl_t w;
		w = CTRL_NOP;
		unique case (pc)
			STEP_ERR: begin
				w.ld_err = 1'b1;
			end
			STEP_STATE: begin
				w.ld_state = 1'b1;
				w.mul_en   = 1'b1;
				w.mul_a    = MA_GP;
				w.mul_b    = MB_ERR;
			end
			STEP_ACC_I: begin
				w.acc_op = ACC_LOAD;
				w.mul_en = 1'b1;
				w.mul_a  = MA_GI;
				w.mul_b  = MB_SUM;
			end
			STEP_ACC_D: begin
				w.acc_op = ACC_ADD;
				w.mul_en = 1'b1;
				w.mul_a  = MA_GD;
				w.mul_b  = MB_DERIV;
			end
			STEP_ACC_END: begin
				w.acc_op = ACC_ADD;
			end
			STEP_CLAMP: begin
				w.ld_drive = 1'b1;
			end
			STEP_DUTY_A: begin
				w.mul_en = 1'b1;
				w.mul_a  = MA_PA;
				w.mul_b  = MB_DRIVE;
			end
			STEP_DUTY_B: begin
				w.acc_op = ACC_LOAD;
				w.mul_en = 1'b1;
				w.mul_a  = MA_PB;
				w.mul_b  = MB_DRIVE;
			end
			STEP_OUT: begin
				w.ld_out = 1'b1;
				w.last   = 1'b1;
				w.jmp    = JMP_OUT_BUSY;
				w.jmp_to = STEP_OUT;
			end
			default: begin
				w = CTRL_NOP;
			end
		endcase
		return w;
	endfunction

	logic [PC_W-1:0] pc_q;
	logic            busy_q;
	ctrl_t           word;
	logic            wait_c;

	always_comb begin
		word   = pcd_rom(pc_q);
		wait_c = busy_q && (word.jmp == JMP_OUT_BUSY) && out_busy;
		// A taken jump suppresses the actions of its step.
		ctrl   = (busy_q && !wait_c) ? word : CTRL_NOP;
	end

	assign busy = busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q   <= '0;
			busy_q <= 1'b0;
		end else if (!busy_q) begin
			if (start) begin
				busy_q <= 1'b1;
				pc_q   <= STEP_ERR;
			end
		end else if (wait_c) begin
			pc_q <= word.jmp_to;
		end else if (word.last) begin
			busy_q <= 1'b0;
		end else begin
			pc_q <= pc_q + 1'b1;
		end
	end

endmodule

### design/pcd_dp.sv
// Datapath of the PID update: error, clamped integral, derivative, one shared
// multiplier with accumulator, drive clamp and duty scaling. Driven by pcd_seq.
// Depends on pcd_pkg.
`timescale 1ns / 1ps

module pcd_dp
	import pcd_pkg::*;
#(
	parameter int unsigned PWM_PERIOD = PWM_PERIOD_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  ctrl_t               ctrl,
	input  logic [TGT_W-1:0]    target,
	input  logic [SAMPLE_W-1:0] sample,
	input  logic [GAIN_W-1:0]   gain_p,
	input  logic [GAIN_W-1:0]   gain_i,
	input  logic [GAIN_W-1:0]   gain_d,
	output logic [DRIVE_W-1:0]  drive,
	output logic [DUTY_W-1:0]   duty
);

	// drive*PWM_PERIOD/255 = drive*PER_A + drive*PER_B/255, with drive*PER_B < 2^16.
	localparam int unsigned PER_A = PWM_PERIOD / DRIVE_MAX;
	localparam int unsigned PER_B = PWM_PERIOD % DRIVE_MAX;

	// Exact floor(y/255) for any 16-bit y below 65535.
	function automatic logic [8:0] div255(input logic [15:0] y);
		logic [16:0] t;
		t = {1'b0, y} + 17'(y[15:8]) + 17'd1;
		return t[16:8];
	endfunction

	logic signed [ERR_W-1:0]   err_q;
	logic signed [SUM_W-1:0]   error_sum_q;
	logic signed [ERR_W-1:0]   prev_err_q;
	logic signed [DERIV_W-1:0] deriv_q;
	logic signed [PROD_W-1:0]  prod_q;
	logic signed [PROD_W-1:0]  acc_q;
	logic [DRIVE_W-1:0]        drive_q;

	logic signed [ERR_W:0]     err_full;
	logic signed [DERIV_W-1:0] sum_full;
	logic signed [SUM_W-1:0]   sum_clamped;
	logic signed [DERIV_W-1:0] deriv_c;
	logic [MUL_A_W-2:0]        mul_a_u;
	logic signed [MUL_A_W-1:0] mul_a;
	logic signed [MUL_B_W-1:0] mul_b;
	logic [DRIVE_W-1:0]        drive_c;
	logic [8:0]                frac_c;

	always_comb begin
		err_full = $signed({3'b000, target}) - $signed({2'b00, sample});
		sum_full = DERIV_W'(error_sum_q) + DERIV_W'(err_q);
		if (sum_full > DERIV_W'(SUM_LIMIT)) begin
			sum_clamped = SUM_W'(SUM_LIMIT);
		end else if (sum_full < -DERIV_W'(SUM_LIMIT)) begin
			sum_clamped = -SUM_W'(SUM_LIMIT);
		end else begin
			sum_clamped = sum_full[SUM_W-1:0];
		end
		deriv_c = DERIV_W'(err_q) - DERIV_W'(prev_err_q);
	end

	always_comb begin
		unique case (ctrl.mul_a)
			MA_GP:   mul_a_u = (MUL_A_W-1)'(gain_p);
			MA_GI:   mul_a_u = (MUL_A_W-1)'(gain_i);
			MA_GD:   mul_a_u = (MUL_A_W-1)'(gain_d);
			MA_PA:   mul_a_u = (MUL_A_W-1)'(PER_A);
			MA_PB:   mul_a_u = (MUL_A_W-1)'(PER_B);
			default: mul_a_u = '0;
		endcase
		mul_a = $signed({1'b0, mul_a_u});
		unique case (ctrl.mul_b)
			MB_ERR:   mul_b = MUL_B_W'(err_q);
			MB_SUM:   mul_b = MUL_B_W'(error_sum_q);
			MB_DERIV: mul_b = deriv_q;
			MB_DRIVE: mul_b = $signed({4'b0000, drive_q});
			default:  mul_b = '0;
		endcase
	end

	always_comb begin
		if (acc_q < 0) begin
			drive_c = '0;
		end else if (acc_q > PROD_W'(DRIVE_MAX)) begin
			drive_c = DRIVE_W'(DRIVE_MAX);
		end else begin
			drive_c = acc_q[DRIVE_W-1:0];
		end
	end

	// At the output step acc_q holds drive*PER_A and prod_q holds drive*PER_B.
	assign frac_c = div255(prod_q[15:0]);
	assign duty   = acc_q[DUTY_W-1:0] + DUTY_W'(frac_c);
	assign drive  = drive_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			error_sum_q <= '0;
			prev_err_q  <= '0;
		end else if (ctrl.ld_state) begin
			error_sum_q <= sum_clamped;
			prev_err_q  <= err_q;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.ld_err) begin
			err_q <= err_full[ERR_W-1:0];
		end
		if (ctrl.ld_state) begin
			deriv_q <= deriv_c;
		end
		if (ctrl.mul_en) begin
			prod_q <= mul_a * mul_b;
		end
		unique case (ctrl.acc_op)
			ACC_LOAD: acc_q <= prod_q;
			ACC_ADD:  acc_q <= acc_q + prod_q;
			default:  acc_q <= acc_q;
		endcase
		if (ctrl.ld_drive) begin
			drive_q <= drive_c;
		end
	end

endmodule

### design/pid_clamped_pwm_duty_top.sv
// Top level of the clamped PID controller with PWM duty output.
// Holds the configuration registers, input capture and output register.
// Depends on pcd_pkg, pcd_seq and pcd_dp.
`timescale 1ns / 1ps

// Usage:
// Samples enter on the input channel (in_valid/in_ready, field sample). Each
// accepted beat runs one PID update and yields one beat on the output channel
// (out_valid/out_ready, fields drive_level and duty_compare).
// Gains and target percent are written over the APB port at byte addresses
// 0, 4, 8 and 12; write them only while no sample is in flight.
// A microcoded program of nine steps runs on one shared multiplier. in_ready
// returns in the same cycle as the result becomes valid, and the next sample
// is taken only once the program of the last one has ended.
// The output register frees the datapath: the next sample is taken while a
// result still waits. If the receiver stalls, the next update waits at its
// final step until the output register is free, and in_ready stays low.
// Reset clears the config registers, the integral and the previous error.
module pid_clamped_pwm_duty_top
	import pcd_pkg::*;
#(
	parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF,
	parameter int unsigned PWM_PERIOD  = PWM_PERIOD_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [ADDR_W-1:0]   paddr,
	input  logic [DATA_W-1:0]   pwdata,
	output logic [DATA_W-1:0]   prdata,
	output logic                pready,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [SAMPLE_W-1:0] sample,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [DRIVE_W-1:0]  drive_level,
	output logic [DUTY_W-1:0]   duty_compare
);

	localparam int unsigned SAMPLE_USED = (SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;
	localparam logic [SAMPLE_W-1:0] SAMPLE_MASK = SAMPLE_W'((1 << SAMPLE_USED) - 1);

	logic [PCT_W-1:0]      target_pct_q;
	logic [GAIN_W-1:0]     gain_p_q;
	logic [GAIN_W-1:0]     gain_i_q;
	logic [GAIN_W-1:0]     gain_d_q;
	logic [TGT_W-1:0]      target_q;
	logic [TGT_PROD_W-1:0] tgt_prod;
	logic [SAMPLE_W-1:0]   sample_q;
	logic                  out_valid_q;
	logic [DRIVE_W-1:0]    drive_level_q;
	logic [DUTY_W-1:0]     duty_compare_q;

	logic                  cfg_wr;
	logic                  in_beat;
	logic                  out_busy;
	logic                  busy;
	ctrl_t                 ctrl;
	logic [DRIVE_W-1:0]    dp_drive;
	logic [DUTY_W-1:0]     dp_duty;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_comb begin
		unique case (paddr[3:2])
			REG_TARGET: prdata = DATA_W'(target_pct_q);
			REG_GAIN_P: prdata = DATA_W'(gain_p_q);
			REG_GAIN_I: prdata = DATA_W'(gain_i_q);
			REG_GAIN_D: prdata = DATA_W'(gain_d_q);
			default:    prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_pct_q <= '0;
			gain_p_q     <= '0;
			gain_i_q     <= '0;
			gain_d_q     <= '0;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				REG_TARGET: target_pct_q <= pwdata[PCT_W-1:0];
				REG_GAIN_P: gain_p_q     <= pwdata[GAIN_W-1:0];
				REG_GAIN_I: gain_i_q     <= pwdata[GAIN_W-1:0];
				REG_GAIN_D: gain_d_q     <= pwdata[GAIN_W-1:0];
				default:    target_pct_q <= target_pct_q;
			endcase
		end
	end

	// The scaled target follows the percent register in the cycle after it changes.
	assign tgt_prod = TGT_PROD_W'(target_pct_q) * TGT_PROD_W'(TGT_MULT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= '0;
		end else begin
			target_q <= tgt_prod[TGT_SHIFT +: TGT_W];
		end
	end

	assign in_ready = !busy;
	assign in_beat  = in_valid && in_ready;
	assign out_busy = out_valid_q && !out_ready;

	always_ff @(posedge clk) begin
		if (in_beat) begin
			sample_q <= sample & SAMPLE_MASK;
		end
	end

	pcd_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (in_beat),
		.out_busy (out_busy),
		.ctrl     (ctrl),
		.busy     (busy)
	);

	pcd_dp #(
		.PWM_PERIOD (PWM_PERIOD)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.target (target_q),
		.sample (sample_q),
		.gain_p (gain_p_q),
		.gain_i (gain_i_q),
		.gain_d (gain_d_q),
		.drive  (dp_drive),
		.duty   (dp_duty)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.ld_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.ld_out) begin
			drive_level_q  <= dp_drive;
			duty_compare_q <= dp_duty;
		end
	end

	assign out_valid    = out_valid_q;
	assign drive_level  = drive_level_q;
	assign duty_compare = duty_compare_q;

endmodule

### tb/testbench.sv
// Self-checking bench for pid_clamped_pwm_duty_top: directed table; fixed, then random phases.
// Each result is checked against a cycle-free clamped PID/duty model or a typed row's values.
// Depends on pcd_pkg and the RTL of the block.
`timescale 1ns / 1ps

module testbench;
	import pcd_pkg::*;

	localparam int PCT_FULL    = 100;
	localparam int DRAIN_WAIT  = 20;
	localparam int LONG_HOLD   = 200;
	localparam int IDLE_LIMIT  = 2000;
	localparam int PHASES      = 8;
	localparam int PHASE_ITEMS = 235;
	localparam int ROWS        = 22;

	typedef struct packed {
		logic [DRIVE_W-1:0] drive;
		logic [DUTY_W-1:0]  duty;
	} pid_result_t;

	// One directed beat with the config it runs under.
	typedef struct packed {
		logic [PCT_W-1:0]    pct;
		logic [GAIN_W-1:0]   gp;
		logic [GAIN_W-1:0]   gi;
		logic [GAIN_W-1:0]   gd;
		logic [SAMPLE_W-1:0] smp;
		logic                typed;
		logic [DRIVE_W-1:0]  drv;
		logic [DUTY_W-1:0]   dty;
	} dir_row_t;

	typedef enum logic [1:0] {
		RX_FREE,
		RX_JITTER,
		RX_SLOW
	} rx_mode_t;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [ADDR_W-1:0]   paddr;
	logic [DATA_W-1:0]   pwdata;
	logic [DATA_W-1:0]   prdata;
	logic                pready;
	logic                in_valid;
	logic                in_ready;
	logic [SAMPLE_W-1:0] sample;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic [DRIVE_W-1:0]  drive_level;
	logic [DUTY_W-1:0]   duty_compare;

	// Mirror of the configuration registers and of the controller state.
	logic [PCT_W-1:0]          cur_pct;
	logic [GAIN_W-1:0]         cur_kp;
	logic [GAIN_W-1:0]         cur_ki;
	logic [GAIN_W-1:0]         cur_kd;
	logic signed [ERR_W-1:0]   last_err;
	logic signed [SUM_W-1:0]   err_integral;

	pid_result_t pending_results[$];
	int          mismatches = 0;
	int          idle_cycles = 0;
	int          hold_asks = 0;
	int          hold_seen = 0;
	int          hold_left = 0;
	int          mode_left = 0;
	rx_mode_t    rx_mode = RX_FREE;

	dir_row_t plan [0:ROWS-1] = '{
		// Reset config: all gains zero, so the output is zero.
		'{7'd0,   8'd0,   8'd0,   8'd0,   10'd0,    1'b1, 8'd0,   10'd0},
		'{7'd0,   8'd0,   8'd0,   8'd0,   10'd1023, 1'b1, 8'd0,   10'd0},
		// Pure proportional, unit gain: drive is the clamped error.
		'{7'd100, 8'd1,   8'd0,   8'd0,   10'd0,    1'b1, 8'd255, 10'd1000},
		'{7'd100, 8'd1,   8'd0,   8'd0,   10'd1023, 1'b1, 8'd0,   10'd0},
		'{7'd100, 8'd1,   8'd0,   8'd0,   10'd1,    1'b0, 8'd0,   10'd0},
		'{7'd100, 8'd1,   8'd0,   8'd0,   10'd128,  1'b0, 8'd0,   10'd0},
		'{7'd50,  8'd1,   8'd0,   8'd0,   10'd127,  1'b1, 8'd0,   10'd0},
		// Target above one hundred percent reaches 323.
		'{7'd127, 8'd1,   8'd0,   8'd0,   10'd323,  1'b1, 8'd0,   10'd0},
		'{7'd127, 8'd1,   8'd0,   8'd0,   10'd0,    1'b1, 8'd255, 10'd1000},
		// Integral saturates at both ends of its range.
		'{7'd100, 8'd0,   8'd1,   8'd0,   10'd0,    1'b0, 8'd0,   10'd0},
		'{7'd100, 8'd0,   8'd1,   8'd0,   10'd0,    1'b0, 8'd0,   10'd0},
		'{7'd100, 8'd0,   8'd1,   8'd0,   10'd1023, 1'b0, 8'd0,   10'd0},
		'{7'd100, 8'd0,   8'd1,   8'd0,   10'd1023, 1'b0, 8'd0,   10'd0},
		'{7'd100, 8'd0,   8'd5,   8'd0,   10'd205,  1'b0, 8'd0,   10'd0},
		// Derivative step up and back down.
		'{7'd60,  8'd0,   8'd0,   8'd2,   10'd153,  1'b0, 8'd0,   10'd0},
		'{7'd60,  8'd0,   8'd0,   8'd2,   10'd100,  1'b0, 8'd0,   10'd0},
		'{7'd60,  8'd0,   8'd0,   8'd2,   10'd153,  1'b0, 8'd0,   10'd0},
		// Full-scale gains with extreme and alternating samples, then small gains.
		'{7'd127, 8'd255, 8'd255, 8'd255, 10'd0,    1'b0, 8'd0,   10'd0},
		'{7'd127, 8'd255, 8'd255, 8'd255, 10'd1023, 1'b0, 8'd0,   10'd0},
		'{7'd127, 8'd255, 8'd255, 8'd255, 10'h2AA,  1'b0, 8'd0,   10'd0},
		'{7'd101, 8'd3,   8'd2,   8'd1,   10'h155,  1'b0, 8'd0,   10'd0},
		'{7'd1,   8'd1,   8'd1,   8'd1,   10'd2,    1'b0, 8'd0,   10'd0}
	};

	pid_clamped_pwm_duty_top dut (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// One PID update on the mirrored state; the state advances as the block's does.
	function automatic pid_result_t pid_step(input logic [SAMPLE_W-1:0] s);
		int          tgt;
		int          err;
		int          acc;
		int          der;
		int          lvl;
		pid_result_t r;
		tgt = int'(cur_pct) * TARGET_SCALE / PCT_FULL;
		err = tgt - int'(s);
		acc = int'(err_integral) + err;
		if (acc > SUM_LIMIT)
			acc = SUM_LIMIT;
		else if (acc < -SUM_LIMIT)
			acc = -SUM_LIMIT;
		der = err - int'(last_err);
		lvl = int'(cur_kp) * err + int'(cur_ki) * acc + int'(cur_kd) * der;
		if (lvl > DRIVE_MAX)
			lvl = DRIVE_MAX;
		else if (lvl < 0)
			lvl = 0;
		r.drive = lvl[DRIVE_W-1:0];
		r.duty = DUTY_W'((lvl * int'(PWM_PERIOD_DEF)) / DRIVE_MAX);
		err_integral = acc[SUM_W-1:0];
		last_err = err[ERR_W-1:0];
		return r;
	endfunction

	// Mostly near the set point so the integral and derivative stay active.
	function automatic logic [SAMPLE_W-1:0] pick_sample();
		int tgt;
		int v;
		tgt = int'(cur_pct) * TARGET_SCALE / PCT_FULL;
		case ($urandom_range(0, 9))
			0: v = 0;
			1: v = 1023;
			2, 3: v = $urandom_range(0, 1023);
			default: begin
				v = tgt + $urandom_range(0, 80) - 40;
				if (v < 0)
					v = 0;
				if (v > 1023)
					v = 1023;
			end
		endcase
		return v[SAMPLE_W-1:0];
	endfunction

	task automatic send_beat(input logic [SAMPLE_W-1:0] v, input logic typed,
			input logic [DRIVE_W-1:0] drv, input logic [DUTY_W-1:0] dty);
		pid_result_t r;
		@(negedge clk);
		in_valid <= 1'b1;
		sample <= v;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		r = pid_step(v);
		if (typed) begin
			r.drive = drv;
			r.duty = dty;
		end
		pending_results.push_back(r);
	endtask

	task automatic pause(input int n);
		if (n > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			sample <= SAMPLE_W'($urandom_range(0, 1023));
			repeat (n - 1)
				@(negedge clk);
		end
	endtask

	task automatic drain();
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [DATA_W-1:0] val);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		case (idx)
			REG_TARGET: cur_pct = val[PCT_W-1:0];
			REG_GAIN_P: cur_kp = val[GAIN_W-1:0];
			REG_GAIN_I: cur_ki = val[GAIN_W-1:0];
			REG_GAIN_D: cur_kd = val[GAIN_W-1:0];
		endcase
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic apply_config(input logic [PCT_W-1:0] pct, input logic [GAIN_W-1:0] gp,
			input logic [GAIN_W-1:0] gi, input logic [GAIN_W-1:0] gd);
		pause(1);
		drain();
		repeat (DRAIN_WAIT)
			@(posedge clk);
		write_reg(REG_TARGET, DATA_W'(pct));
		write_reg(REG_GAIN_P, DATA_W'(gp));
		write_reg(REG_GAIN_I, DATA_W'(gi));
		write_reg(REG_GAIN_D, DATA_W'(gd));
	endtask

	function automatic logic [GAIN_W-1:0] pick_gain();
		if ($urandom_range(0, 9) < 7)
			return GAIN_W'($urandom_range(0, 15));
		return GAIN_W'($urandom_range(0, 255));
	endfunction

	// Receiver: stall pattern of its own, plus a long hold on request.
	always @(negedge clk) begin
		if (hold_asks != hold_seen) begin
			hold_seen = hold_asks;
			hold_left = LONG_HOLD;
		end
		if (mode_left == 0) begin
			rx_mode = rx_mode_t'($urandom_range(0, 2));
			mode_left = $urandom_range(8, 80);
		end else
			mode_left--;
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			case (rx_mode)
				RX_FREE: out_ready <= 1'b1;
				RX_JITTER: out_ready <= 1'($urandom_range(0, 1));
				default: out_ready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	always @(posedge clk) begin
		pid_result_t e;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				$error("unexpected result beat: drive_level %0d, duty_compare %0d",
					drive_level, duty_compare);
				mismatches++;
			end else begin
				e = pending_results.pop_front();
				if (drive_level !== e.drive) begin
					$error("drive_level: expected %0d, got %0d", e.drive, drive_level);
					mismatches++;
				end
				if (duty_compare !== e.duty) begin
					$error("duty_compare: expected %0d, got %0d", e.duty, duty_compare);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		int  ph;
		int  sent;
		int  burst;
		int  k;
		bit  held;
		bit  paused;
		logic [PCT_W-1:0]  pct;
		logic [GAIN_W-1:0] gp;
		logic [GAIN_W-1:0] gi;
		logic [GAIN_W-1:0] gd;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		sample = '0;
		cur_pct = '0;
		cur_kp = '0;
		cur_ki = '0;
		cur_kd = '0;
		last_err = '0;
		err_integral = '0;
		held = 1'b0;
		paused = 1'b0;
		repeat (12)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (k = 0; k < ROWS; k++) begin
			if (plan[k].pct != cur_pct || plan[k].gp != cur_kp || plan[k].gi != cur_ki ||
					plan[k].gd != cur_kd)
				apply_config(plan[k].pct, plan[k].gp, plan[k].gi, plan[k].gd);
			send_beat(plan[k].smp, plan[k].typed, plan[k].drv, plan[k].dty);
		end

		for (ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: begin pct = 7'd127; gp = 8'd255; gi = 8'd255; gd = 8'd255; end
				1: begin pct = 7'd0; gp = 8'd0; gi = 8'd0; gd = 8'd0; end
				2: begin pct = 7'd100; gp = 8'd1; gi = 8'd1; gd = 8'd1; end
				default: begin
					pct = PCT_W'($urandom_range(0, 127));
					gp = pick_gain();
					gi = pick_gain();
					gd = pick_gain();
				end
			endcase
			apply_config(pct, gp, gi, gd);
			sent = 0;
			while (sent < PHASE_ITEMS) begin
				// The receiver holds off while beats keep coming, so the block backs up.
				if (ph == 3 && sent >= 60 && !held) begin
					hold_asks++;
					held = 1'b1;
				end
				if (ph == 5 && sent >= 100 && !paused) begin
					pause(1);
					drain();
					paused = 1'b1;
				end
				burst = $urandom_range(1, 24);
				for (k = 0; k < burst && sent < PHASE_ITEMS; k++) begin
					send_beat(pick_sample(), 1'b0, '0, '0);
					sent++;
				end
				if ($urandom_range(0, 3) != 0)
					pause($urandom_range(1, 12));
			end
		end

		pause(1);
		drain();
		repeat (DRAIN_WAIT)
			@(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
